>>> rtl/vatb_pkg.sv
// Package: types, constants and arithmetic helpers for the vertex transform and bounds unit.
`timescale 1ns / 1ps

package vatb_pkg;

    localparam int COORD_BITS = 16;
    localparam int NRM_BITS   = 16;
    localparam int COEF_BITS  = 16;
    localparam int ROW_BITS   = 64;
    localparam int FRAC_SHIFT = 12;

    localparam int PP_W    = COORD_BITS + COEF_BITS;
    localparam int NP_W    = NRM_BITS + COEF_BITS;
    localparam int ACC_W   = COORD_BITS + COEF_BITS + 3;
    localparam int NACC_W  = NRM_BITS + COEF_BITS + 3;
    localparam int SH_W    = ACC_W - FRAC_SHIFT;
    localparam int NSH_W   = NACC_W - FRAC_SHIFT;

    localparam int CFG_IDX_BITS = 2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ROW_X = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ROW_Y = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ROW_Z = 2'd2;

    localparam logic [ROW_BITS-1:0] ROW_X_RST = 64'h0000_0000_0000_1000;
    localparam logic [ROW_BITS-1:0] ROW_Y_RST = 64'h0000_0000_1000_0000;
    localparam logic [ROW_BITS-1:0] ROW_Z_RST = 64'h0000_1000_0000_0000;

    typedef enum logic [1:0] {
        KIND_VERTEX = 2'd0,
        KIND_MIN    = 2'd1,
        KIND_MAX    = 2'd2,
        KIND_CTR    = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        SEQ_IDLE = 2'd0,
        SEQ_MIN  = 2'd1,
        SEQ_MAX  = 2'd2,
        SEQ_CTR  = 2'd3
    } t_seq;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] pos_x;
        logic signed [COORD_BITS-1:0] pos_y;
        logic signed [COORD_BITS-1:0] pos_z;
        logic signed [NRM_BITS-1:0]   nrm_x;
        logic signed [NRM_BITS-1:0]   nrm_y;
        logic signed [NRM_BITS-1:0]   nrm_z;
        logic                         object_end;
    } t_in;

    typedef struct packed {
        t_kind                        kind;
        logic signed [COORD_BITS-1:0] out_x;
        logic signed [COORD_BITS-1:0] out_y;
        logic signed [COORD_BITS-1:0] out_z;
        logic signed [NRM_BITS-1:0]   out_nx;
        logic signed [NRM_BITS-1:0]   out_ny;
        logic signed [NRM_BITS-1:0]   out_nz;
        logic                         run_last;
    } t_out;

    typedef struct packed {
        logic [2:0][ROW_BITS-1:0] row;
    } t_matrix;

    typedef struct packed {
        logic [2:0][COORD_BITS-1:0] pos;
        logic [2:0][NRM_BITS-1:0]   nrm;
        logic                       object_end;
    } t_xres;

    function automatic logic signed [COEF_BITS-1:0] row_coef(
        input logic [ROW_BITS-1:0] row,
        input logic [1:0]          sel
    );
        return row[COEF_BITS*sel +: COEF_BITS];
    endfunction

    // clamp a shifted accumulator to the signed coordinate range
    function automatic logic [COORD_BITS-1:0] sat_pos(input logic [SH_W-1:0] v);
        logic fits;
        fits = (&v[SH_W-1:COORD_BITS-1]) || !(|v[SH_W-1:COORD_BITS-1]);
        if (fits)
            return v[COORD_BITS-1:0];
        return v[SH_W-1] ? {1'b1, {(COORD_BITS-1){1'b0}}} : {1'b0, {(COORD_BITS-1){1'b1}}};
    endfunction

    function automatic logic [NRM_BITS-1:0] sat_nrm(input logic [NSH_W-1:0] v);
        logic fits;
        fits = (&v[NSH_W-1:NRM_BITS-1]) || !(|v[NSH_W-1:NRM_BITS-1]);
        if (fits)
            return v[NRM_BITS-1:0];
        return v[NSH_W-1] ? {1'b1, {(NRM_BITS-1){1'b0}}} : {1'b0, {(NRM_BITS-1){1'b1}}};
    endfunction

endpackage

>>> rtl/vatb_xform.sv
// Transform pipeline: input register, product register, rounded and saturated result register.
`timescale 1ns / 1ps

module vatb_xform (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  vatb_pkg::t_matrix i_mat,
    input  logic             i_valid,
    input  vatb_pkg::t_in    i_in,
    output logic             o_stall,
    output logic             o_valid,
    output vatb_pkg::t_xres  o_res,
    input  logic             i_take
);
    import vatb_pkg::*;

    localparam logic signed [ACC_W-1:0]  RND_P = ACC_W'(2048);
    localparam logic signed [NACC_W-1:0] RND_N = NACC_W'(2048);

    logic r_a_valid, r_b_valid, r_c_valid;
    logic en_a, en_b, en_c;

    t_in  r_a;
    logic signed [COORD_BITS-1:0] a_pos [3];
    logic signed [NRM_BITS-1:0]   a_nrm [3];

    logic signed [PP_W-1:0]      r_b_pp [3][3];
    logic signed [NP_W-1:0]      r_b_np [3][3];
    logic signed [COEF_BITS-1:0] r_b_t  [3];
    logic                        r_b_end;

    logic signed [ACC_W-1:0]  acc_p [3];
    logic signed [NACC_W-1:0] acc_n [3];
    t_xres n_c, r_c;

    assign en_c    = !r_c_valid || i_take;
    assign en_b    = !r_b_valid || en_c;
    assign en_a    = !r_a_valid || en_b;
    assign o_stall = !en_a;
    assign o_valid = r_c_valid;
    assign o_res   = r_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else begin
            if (en_a)
                r_a_valid <= i_valid;
            if (en_b)
                r_b_valid <= r_a_valid;
            if (en_c)
                r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_a && i_valid)
            r_a <= i_in;
    end

    always_comb begin
        a_pos[0] = r_a.pos_x;
        a_pos[1] = r_a.pos_y;
        a_pos[2] = r_a.pos_z;
        a_nrm[0] = r_a.nrm_x;
        a_nrm[1] = r_a.nrm_y;
        a_nrm[2] = r_a.nrm_z;
    end

    always_ff @(posedge i_clk) begin
        if (en_b && r_a_valid) begin
            for (int r = 0; r < 3; r++) begin
                for (int j = 0; j < 3; j++) begin
                    r_b_pp[r][j] <= row_coef(i_mat.row[r], 2'(j)) * a_pos[j];
                    r_b_np[r][j] <= row_coef(i_mat.row[r], 2'(j)) * a_nrm[j];
                end
                r_b_t[r] <= row_coef(i_mat.row[r], 2'd3);
            end
            r_b_end <= r_a.object_end;
        end
    end

    // sum, round half up, floor shift, saturate
    always_comb begin
        n_c.object_end = r_b_end;
        for (int r = 0; r < 3; r++) begin
            acc_p[r] = ACC_W'(r_b_pp[r][0]) + ACC_W'(r_b_pp[r][1]) + ACC_W'(r_b_pp[r][2])
                     + (ACC_W'(r_b_t[r]) <<< FRAC_SHIFT) + RND_P;
            acc_n[r] = NACC_W'(r_b_np[r][0]) + NACC_W'(r_b_np[r][1])
                     + NACC_W'(r_b_np[r][2]) + RND_N;
            n_c.pos[r] = sat_pos(acc_p[r][ACC_W-1:FRAC_SHIFT]);
            n_c.nrm[r] = sat_nrm(acc_n[r][NACC_W-1:FRAC_SHIFT]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_c && r_b_valid)
            r_c <= n_c;
    end

endmodule

>>> rtl/vertex_affine_transform_bounds_unit.sv
// Top level: matrix registers, bounding box tracking and result sequencing.
`timescale 1ns / 1ps

// Vertex affine transform with per-object bounding box.
// Input channel (i_valid / o_stall, payload i_in): one vertex per item, with
// position, normal and an object_end flag. Output channel (o_valid / i_stall,
// payload o_out): one transformed-vertex item per vertex; a vertex with
// object_end set is followed by min, max and center items, run_last high on
// the last item caused by that vertex.
// Matrix rows are written through i_cfg_we / i_cfg_idx / i_cfg_data; the user
// must write them only while idle, the block does not enforce this. Indexes
// beyond the third row are ignored. A vertex result passes the input, product
// and result registers, then the output register. Throughput: one vertex per
// cycle while the receiver does not stall and no bound items are pending; an
// object_end vertex holds the pipeline until its min, max, center items issue.
// Reset loads the identity matrix, empties the box and drops all items in
// flight. While the receiver stalls, the output item holds and the pipeline
// fills, after which o_stall rises.
module vertex_affine_transform_bounds_unit (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [vatb_pkg::CFG_IDX_BITS-1:0]     i_cfg_idx,
    input  logic [vatb_pkg::ROW_BITS-1:0]         i_cfg_data,
    input  logic                                  i_valid,
    input  vatb_pkg::t_in                         i_in,
    output logic                                  o_stall,
    output logic                                  o_valid,
    output vatb_pkg::t_out                        o_out,
    input  logic                                  i_stall
);
    import vatb_pkg::*;

    t_matrix r_mat;
    logic    c_valid, take_c, out_free;
    t_xres   c_res;

    t_seq r_seq, n_seq;
    logic r_o_valid, n_o_valid;
    t_out r_o, n_o;

    logic [2:0][COORD_BITS-1:0] r_box_min, r_box_max;
    logic                       r_box_empty;
    logic [COORD_BITS-1:0]      ctr [3];
    logic [COORD_BITS:0]        ctr_sum [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mat.row[0] <= ROW_X_RST;
            r_mat.row[1] <= ROW_Y_RST;
            r_mat.row[2] <= ROW_Z_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ROW_X: r_mat.row[0] <= i_cfg_data;
                CFG_ROW_Y: r_mat.row[1] <= i_cfg_data;
                CFG_ROW_Z: r_mat.row[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    vatb_xform u_xform (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_mat   (r_mat),
        .i_valid (i_valid),
        .i_in    (i_in),
        .o_stall (o_stall),
        .o_valid (c_valid),
        .o_res   (c_res),
        .i_take  (take_c)
    );

    assign out_free = !r_o_valid || !i_stall;
    assign take_c   = c_valid && out_free && (r_seq == SEQ_IDLE);

    // box merge
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box_min   <= '0;
            r_box_max   <= '0;
            r_box_empty <= 1'b1;
        end else if (take_c) begin
            for (int i = 0; i < 3; i++) begin
                if (r_box_empty || ($signed(c_res.pos[i]) < $signed(r_box_min[i])))
                    r_box_min[i] <= c_res.pos[i];
                if (r_box_empty || ($signed(c_res.pos[i]) > $signed(r_box_max[i])))
                    r_box_max[i] <= c_res.pos[i];
            end
            r_box_empty <= c_res.object_end;
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            ctr_sum[i] = {r_box_min[i][COORD_BITS-1], r_box_min[i]}
                       + {r_box_max[i][COORD_BITS-1], r_box_max[i]};
            ctr[i]     = ctr_sum[i][COORD_BITS:1];
        end
    end

    always_comb begin
        n_seq = r_seq;
        unique case (r_seq)
            SEQ_IDLE: if (take_c && c_res.object_end) n_seq = SEQ_MIN;
            SEQ_MIN:  if (out_free) n_seq = SEQ_MAX;
            SEQ_MAX:  if (out_free) n_seq = SEQ_CTR;
            SEQ_CTR:  if (out_free) n_seq = SEQ_IDLE;
            default:  n_seq = SEQ_IDLE;
        endcase
    end

    always_comb begin
        n_o_valid = r_o_valid && i_stall;
        n_o       = r_o;
        unique case (r_seq)
            SEQ_IDLE: begin
                if (take_c) begin
                    n_o_valid = 1'b1;
                    n_o.kind  = KIND_VERTEX;
                    n_o.out_x = c_res.pos[0];
                    n_o.out_y = c_res.pos[1];
                    n_o.out_z = c_res.pos[2];
                    n_o.out_nx = c_res.nrm[0];
                    n_o.out_ny = c_res.nrm[1];
                    n_o.out_nz = c_res.nrm[2];
                    n_o.run_last = !c_res.object_end;
                end
            end
            SEQ_MIN: begin
                if (out_free) begin
                    n_o_valid = 1'b1;
                    n_o = '{KIND_MIN, r_box_min[0], r_box_min[1], r_box_min[2],
                            '0, '0, '0, 1'b0};
                end
            end
            SEQ_MAX: begin
                if (out_free) begin
                    n_o_valid = 1'b1;
                    n_o = '{KIND_MAX, r_box_max[0], r_box_max[1], r_box_max[2],
                            '0, '0, '0, 1'b0};
                end
            end
            SEQ_CTR: begin
                if (out_free) begin
                    n_o_valid = 1'b1;
                    n_o = '{KIND_CTR, ctr[0], ctr[1], ctr[2], '0, '0, '0, 1'b1};
                end
            end
            default: n_o_valid = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq     <= SEQ_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            r_seq     <= n_seq;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_o <= n_o;
    end

    assign o_valid = r_o_valid;
    assign o_out   = r_o;

    a_end_then_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && o_out.kind == KIND_VERTEX && !o_out.run_last)
        |=> (o_valid && o_out.kind == KIND_MIN))
        else $error("min item does not follow object end vertex");

    a_min_then_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && o_out.kind == KIND_MIN)
        |=> (o_valid && o_out.kind == KIND_MAX))
        else $error("max item does not follow min item");

    a_ctr_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_out.kind == KIND_CTR)) |-> o_out.run_last)
        else $error("center item without run_last");

    a_bound_nrm_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_out.kind != KIND_VERTEX)
        |-> (o_out.out_nx == '0 && o_out.out_ny == '0 && o_out.out_nz == '0))
        else $error("bound item carries a normal");

    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_seq != SEQ_IDLE) |-> !take_c)
        else $error("vertex taken while bounds pending");

endmodule
